FILE: hw/rtl/sbqt_pkg.sv
// ----------------------------------------------------------------------------
// sbqt_pkg - shared types for the semaphore blocked queue table
// Opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package sbqt_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_OUT    = 2'd2;
  localparam logic [1:0] OP_HEAD   = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_RSVD     = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ORD,
    ST_OKEY,
    ST_SCAN,
    ST_EXEC,
    ST_WCHK,
    ST_WNXT,
    ST_FIX,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/semaphore_blocked_queue_table.sv
// ----------------------------------------------------------------------------
// semaphore_blocked_queue_table - table of semaphores with blocked queues
// Keyed descriptors, each holding a linked FIFO of blocked process indices.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command transaction:
//   opcode, semaphore key and process index. Result channel
//   (out_valid/out_stall) returns one transaction per command: status and
//   the process removed, taken out or at the head.
//   Throughput: one command at a time. Every command that is not rejected
//   runs a key search over the descriptor memory, one entry per cycle
//   through a single comparator. Remove also follows a link when its queue
//   holds more than one process; out first reads the key its process is
//   blocked on and, after the search, walks the queue to find the
//   predecessor. Rejected commands skip the search and go straight to the
//   response. A new command is taken in the cycle after the result loads.
//   A finished result sits in the output register; the next command is taken
//   while it waits, and a later result holds in its final state until the
//   receiver drops stall.
//   Reset frees every descriptor and marks every process unblocked through
//   flip-flop flags; the memories themselves need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module semaphore_blocked_queue_table
  import sbqt_pkg::*;
#(
  parameter int NUM_DESCRIPTORS = 32,
  parameter int NUM_PROCS       = 32,
  parameter int KEY_BITS        = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_sem_key,
  input  wire logic [4:0]  in_proc_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [4:0]       out_proc_out
);

  localparam int DW = $clog2(NUM_DESCRIPTORS);
  localparam int PW = $clog2(NUM_PROCS);
  localparam logic [DW-1:0] LAST_DESC = DW'(NUM_DESCRIPTORS - 1);

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [PW-1:0]       head;
    logic [PW-1:0]       tail;
  } desc_t;

  // Descriptor record memory and per-process memories
  desc_t               desc_mem [NUM_DESCRIPTORS];
  logic [PW-1:0]       pn_mem   [NUM_PROCS];
  logic [KEY_BITS-1:0] pk_mem   [NUM_PROCS];

  state_t state_r, state_nxt;

  logic [NUM_DESCRIPTORS-1:0] used_r, used_nxt;
  logic [NUM_PROCS-1:0]       blk_r, blk_nxt;

  logic [1:0]          op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [PW-1:0]       p_r, p_nxt;
  logic [DW-1:0]       d_r, d_nxt;
  logic [DW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic                hit_r, hit_nxt;
  logic [DW-1:0]       fd_r, fd_nxt;
  logic [DW-1:0]       free_r, free_nxt;
  logic                free_vld_r, free_vld_nxt;
  logic [PW-1:0]       hd_r, hd_nxt;
  logic [PW-1:0]       tl_r, tl_nxt;
  logic [PW-1:0]       cur_r, cur_nxt;
  logic [PW-1:0]       prev_r, prev_nxt;
  logic                prev_vld_r, prev_vld_nxt;
  logic [1:0]          st_r, st_nxt;
  logic [PW-1:0]       res_r, res_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [4:0] out_proc_r, out_proc_nxt;

  // Memory ports
  desc_t               desc_q;
  logic                desc_we;
  logic [DW-1:0]       desc_waddr;
  desc_t               desc_wdata;
  logic [PW-1:0]       pn_q;
  logic [PW-1:0]       pn_raddr;
  logic                pn_we;
  logic [PW-1:0]       pn_waddr;
  logic [PW-1:0]       pn_wdata;
  logic [KEY_BITS-1:0] pk_q;
  logic                pk_we;

  // Incoming key masked to KEY_BITS, process index range check
  logic [KEY_BITS-1:0] key_in;
  logic [PW-1:0]       p_in;
  logic                p_ok;

  assign key_in = KEY_BITS'({32'd0, in_sem_key});
  assign p_in   = PW'(in_proc_index);
  assign p_ok   = (32'(in_proc_index) < NUM_PROCS);

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_proc_out = out_proc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      blk_r       <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      blk_r       <= blk_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    p_r          <= p_nxt;
    d_r          <= d_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    fd_r         <= fd_nxt;
    free_r       <= free_nxt;
    free_vld_r   <= free_vld_nxt;
    hd_r         <= hd_nxt;
    tl_r         <= tl_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    prev_vld_r   <= prev_vld_nxt;
    st_r         <= st_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_proc_r   <= out_proc_nxt;
  end

  // Memories: one write and one registered read each per cycle
  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[desc_waddr] <= desc_wdata;
    end
    desc_q <= desc_mem[d_r];
  end

  always_ff @(posedge clk) begin
    if (pn_we) begin
      pn_mem[pn_waddr] <= pn_wdata;
    end
    pn_q <= pn_mem[pn_raddr];
  end

  always_ff @(posedge clk) begin
    if (pk_we) begin
      pk_mem[p_r] <= key_r;
    end
    pk_q <= pk_mem[p_r];
  end

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    blk_nxt        = blk_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    p_nxt          = p_r;
    d_nxt          = d_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    hit_nxt        = hit_r;
    fd_nxt         = fd_r;
    free_nxt       = free_r;
    free_vld_nxt   = free_vld_r;
    hd_nxt         = hd_r;
    tl_nxt         = tl_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    prev_vld_nxt   = prev_vld_r;
    st_nxt         = st_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_proc_nxt   = out_proc_r;
    desc_we        = 1'b0;
    desc_waddr     = fd_r;
    desc_wdata     = '{key: key_r, head: hd_r, tail: tl_r};
    pn_raddr       = cur_r;
    pn_we          = 1'b0;
    pn_waddr       = tl_r;
    pn_wdata       = p_r;
    pk_we          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_opcode;
          key_nxt      = key_in;
          p_nxt        = p_in;
          d_nxt        = '0;
          hit_nxt      = 1'b0;
          free_vld_nxt = 1'b0;
          prev_vld_nxt = 1'b0;
          st_nxt       = STAT_NOTFOUND;
          res_nxt      = '0;
          case (in_opcode)
            OP_INSERT: begin
              if (!p_ok || key_in == '0 || blk_r[p_in]) begin
                state_nxt = ST_RESP;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            OP_OUT: begin
              if (!p_ok || !blk_r[p_in]) begin
                state_nxt = ST_RESP;
              end else begin
                state_nxt = ST_ORD;
              end
            end
            default: begin
              state_nxt = (key_in == '0) ? ST_RESP : ST_SCAN;
            end
          endcase
        end
      end
      ST_ORD: begin
        state_nxt = ST_OKEY;
      end
      ST_OKEY: begin
        key_nxt   = pk_q;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        d_nxt       = (d_r == LAST_DESC) ? d_r : d_r + 1'b1;
        cmp_idx_nxt = d_r;
        cmp_vld_nxt = 1'b1;
        if (cmp_vld_r) begin
          if (used_r[cmp_idx_r] && desc_q.key == key_r) begin
            hit_nxt   = 1'b1;
            fd_nxt    = cmp_idx_r;
            hd_nxt    = desc_q.head;
            tl_nxt    = desc_q.tail;
            state_nxt = ST_EXEC;
          end else begin
            if (!used_r[cmp_idx_r] && !free_vld_r) begin
              free_nxt     = cmp_idx_r;
              free_vld_nxt = 1'b1;
            end
            if (cmp_idx_r == LAST_DESC) begin
              state_nxt = ST_EXEC;
            end
          end
        end
      end
      ST_EXEC: begin
        state_nxt = ST_RESP;
        case (op_r)
          OP_INSERT: begin
            if (hit_r) begin
              pn_we         = 1'b1;
              desc_we       = 1'b1;
              desc_wdata    = '{key: key_r, head: hd_r, tail: p_r};
              blk_nxt[p_r]  = 1'b1;
              pk_we         = 1'b1;
              st_nxt        = STAT_OK;
            end else if (free_vld_r) begin
              used_nxt[free_r] = 1'b1;
              desc_we          = 1'b1;
              desc_waddr       = free_r;
              desc_wdata       = '{key: key_r, head: p_r, tail: p_r};
              blk_nxt[p_r]     = 1'b1;
              pk_we            = 1'b1;
              st_nxt           = STAT_OK;
            end else begin
              st_nxt = STAT_FULL;
            end
          end
          OP_HEAD: begin
            if (hit_r) begin
              st_nxt  = STAT_OK;
              res_nxt = hd_r;
            end
          end
          OP_REMOVE: begin
            if (hit_r) begin
              st_nxt        = STAT_OK;
              res_nxt       = hd_r;
              blk_nxt[hd_r] = 1'b0;
              if (hd_r == tl_r) begin
                used_nxt[fd_r] = 1'b0;
              end else begin
                pn_raddr  = hd_r;
                state_nxt = ST_FIX;
              end
            end
          end
          default: begin
            if (hit_r) begin
              cur_nxt      = hd_r;
              prev_vld_nxt = 1'b0;
              state_nxt    = ST_WCHK;
            end
          end
        endcase
      end
      ST_WCHK: begin
        if (cur_r == p_r) begin
          pn_raddr  = p_r;
          state_nxt = ST_FIX;
        end else if (cur_r == tl_r) begin
          state_nxt = ST_RESP;
        end else begin
          pn_raddr     = cur_r;
          prev_nxt     = cur_r;
          prev_vld_nxt = 1'b1;
          state_nxt    = ST_WNXT;
        end
      end
      ST_WNXT: begin
        cur_nxt   = pn_q;
        state_nxt = ST_WCHK;
      end
      ST_FIX: begin
        state_nxt = ST_RESP;
        if (op_r == OP_REMOVE) begin
          desc_we    = 1'b1;
          desc_wdata = '{key: key_r, head: pn_q, tail: tl_r};
        end else begin
          blk_nxt[p_r] = 1'b0;
          st_nxt       = STAT_OK;
          res_nxt      = p_r;
          if (!prev_vld_r) begin
            if (p_r == tl_r) begin
              used_nxt[fd_r] = 1'b0;
            end else begin
              desc_we    = 1'b1;
              desc_wdata = '{key: key_r, head: pn_q, tail: tl_r};
            end
          end else begin
            pn_we    = 1'b1;
            pn_waddr = prev_r;
            pn_wdata = pn_q;
            if (p_r == tl_r) begin
              desc_we    = 1'b1;
              desc_wdata = '{key: key_r, head: hd_r, tail: prev_r};
            end
          end
        end
      end
      ST_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_proc_nxt   = (st_r == STAT_OK) ? 5'(res_r) : 5'd0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("command taken without going busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != STAT_RSVD))
    else $error("reserved status code driven");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> (out_proc_out == 5'd0))
    else $error("failed command returned a process");

  a_blk_needs_desc: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r == '0) |-> (blk_r == '0))
    else $error("process blocked with no descriptor in use");
`endif

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for the semaphore blocked queue table
// Drives command transactions through named test tasks, predicts every result
// with a behavioural copy of the table and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import sbqt_pkg::*;

  localparam int NDESC = 32;
  localparam int NPROC = 32;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = OP_INSERT;
  logic [31:0] in_sem_key = '0;
  logic [4:0]  in_proc_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [4:0]  out_proc_out;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] proc_id;
  } sem_result_t;

  // predictor copy of the table
  logic        tbl_used [NDESC];
  logic [31:0] tbl_key  [NDESC];
  logic [4:0]  tbl_head [NDESC];
  logic [4:0]  tbl_tail [NDESC];
  logic [4:0]  link_next [NPROC];
  logic [31:0] blocked_on [NPROC];

  sem_result_t pending_results[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  always #5 clk = ~clk;

  semaphore_blocked_queue_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_sem_key(in_sem_key), .in_proc_index(in_proc_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_proc_out(out_proc_out)
  );

  function automatic int find_slot(logic [31:0] key);
    if (key == 0) return -1;
    for (int d = 0; d < NDESC; d++)
      if (tbl_used[d] && tbl_key[d] == key) return d;
    return -1;
  endfunction

  // Work out the result of one command and advance the predictor state.
  function automatic sem_result_t table_apply(logic [1:0] op, logic [31:0] key,
                                              logic [4:0] p);
    sem_result_t r;
    int d;
    int cur;
    int prev;
    r.status = STAT_NOTFOUND;
    r.proc_id = '0;
    case (op)
      OP_INSERT: begin
        if (key != 0 && blocked_on[p] == 0) begin
          d = find_slot(key);
          if (d < 0) begin
            for (int i = 0; i < NDESC; i++)
              if (!tbl_used[i] && d < 0) d = i;
            if (d < 0) begin
              r.status = STAT_FULL;
            end else begin
              tbl_used[d] = 1'b1;
              tbl_key[d] = key;
              tbl_head[d] = p;
              tbl_tail[d] = p;
              r.status = STAT_OK;
            end
          end else begin
            link_next[tbl_tail[d]] = p;
            tbl_tail[d] = p;
            r.status = STAT_OK;
          end
          if (r.status == STAT_OK) blocked_on[p] = key;
        end
      end
      OP_REMOVE, OP_HEAD: begin
        d = find_slot(key);
        if (d >= 0) begin
          r.status = STAT_OK;
          r.proc_id = tbl_head[d];
          if (op == OP_REMOVE) begin
            blocked_on[tbl_head[d]] = '0;
            if (tbl_head[d] == tbl_tail[d]) tbl_used[d] = 1'b0;
            else tbl_head[d] = link_next[tbl_head[d]];
          end
        end
      end
      default: begin
        if (blocked_on[p] != 0) begin
          d = find_slot(blocked_on[p]);
          if (d >= 0) begin
            cur = tbl_head[d];
            prev = -1;
            // walk the queue to the process, remembering its predecessor
            for (int s = 0; s < NPROC && cur != p && cur != tbl_tail[d]; s++) begin
              prev = cur;
              cur = link_next[cur];
            end
            if (cur == p) begin
              if (prev < 0) begin
                if (p == tbl_tail[d]) tbl_used[d] = 1'b0;
                else tbl_head[d] = link_next[p];
              end else begin
                link_next[prev] = link_next[p];
                if (p == tbl_tail[d]) tbl_tail[d] = prev[4:0];
              end
              blocked_on[p] = '0;
              r.status = STAT_OK;
              r.proc_id = p;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  // Send one command transaction; hold the payload until accepted.
  task automatic send_cmd(logic [1:0] op, logic [31:0] key, logic [4:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_sem_key <= key;
    in_proc_index <= p;
    pending_results.push_back(table_apply(op, key, p));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall, check each accepted result against the oldest.
  always @(posedge clk) begin
    sem_result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d %0d", out_status, out_proc_out);
        end else begin
          exp_r = pending_results.pop_front();
          if (exp_r.status !== out_status || exp_r.proc_id !== out_proc_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d proc %0d, got status %0d proc %0d",
                       exp_r.status, exp_r.proc_id, out_status, out_proc_out);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Directed: extremes, every opcode and each special case.
  task automatic test_directed();
    send_cmd(OP_INSERT, 32'h0, 5'd1);          // zero key rejected
    send_cmd(OP_REMOVE, 32'h0, 5'd0);          // zero key, nothing found
    send_cmd(OP_HEAD, 32'h1234, 5'd0);         // unknown key
    send_cmd(OP_OUT, 32'h0, 5'd3);             // process not blocked
    send_cmd(OP_INSERT, 32'hFFFF_FFFF, 5'd31);
    send_cmd(OP_INSERT, 32'hFFFF_FFFF, 5'd0);
    send_cmd(OP_INSERT, 32'hFFFF_FFFF, 5'd7);
    send_cmd(OP_INSERT, 32'h1, 5'd31);         // already blocked
    send_cmd(OP_HEAD, 32'hFFFF_FFFF, 5'd0);
    send_cmd(OP_OUT, 32'h0, 5'd0);             // middle of the queue
    send_cmd(OP_OUT, 32'hFFFF_FFFF, 5'd7);     // tail of the queue
    send_cmd(OP_REMOVE, 32'hFFFF_FFFF, 5'd0);  // head leaves, the tail stays queued
    send_cmd(OP_REMOVE, 32'hFFFF_FFFF, 5'd0);
    send_cmd(OP_INSERT, 32'h1, 5'd5);
    send_cmd(OP_OUT, 32'h0, 5'd5);             // head and tail at once
    wait_drained();
  endtask

  // Fill every descriptor, probe the edges of a full table and drain again.
  task automatic test_table_full();
    for (int i = 0; i < NPROC; i++) send_cmd(OP_INSERT, 32'h100 + i, i[4:0]);
    wait_drained();
    send_cmd(OP_INSERT, 32'h1, 5'd0);          // already blocked
    send_cmd(OP_OUT, 32'h0, 5'd9);
    send_cmd(OP_INSERT, 32'hDEAD_BEEF, 5'd9);
    send_cmd(OP_OUT, 32'h0, 5'd9);
    for (int i = 0; i < NPROC; i++) send_cmd(OP_REMOVE, 32'h100 + i, 5'd0);
    wait_drained();
  endtask

  // Random: mostly a small key pool so queues grow deep, some noise keys.
  task automatic test_random(int n);
    logic [31:0] k;
    logic [1:0]  op;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: k = $urandom();
        1: k = 32'h0;
        default: k = 32'h8000_0000 | $urandom_range(5);
      endcase
      op = $urandom_range(99) < 40 ? OP_INSERT : 2'($urandom_range(3));
      send_cmd(op, k, 5'($urandom_range(31)));
    end
  endtask

  initial begin
    for (int d = 0; d < NDESC; d++) begin
      tbl_used[d] = 1'b0;
      tbl_key[d] = '0;
      tbl_head[d] = '0;
      tbl_tail[d] = '0;
    end
    for (int p = 0; p < NPROC; p++) begin
      link_next[p] = '0;
      blocked_on[p] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    send_idle_pct = 25;
    recv_idle_pct = 72;
    test_random(160);
    wait_drained();                            // pause the sender until drained
    send_idle_pct = 72;
    recv_idle_pct = 25;
    test_random(160);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(150);
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
hw/rtl/sbqt_pkg.sv
hw/rtl/semaphore_blocked_queue_table.sv
test/tb_top.sv
